/* hdl/ypcam_pkg.sv */
// Shared constants, types and helpers for the yaw/pitch camera update block.
package ypcam_pkg;

    localparam int POS_FRAC_BITS   = 16;
    localparam int TRIG_ITERATIONS = 16;
    localparam int MOVE_SHIFT      = 39 - POS_FRAC_BITS;
    localparam int YAW_FULL        = 46080;
    localparam int PITCH_LIMIT     = 11392;
    localparam int CORDIC_GAIN     = 652032874;
    localparam int RECIP45         = 46604;
    localparam int ATAN_COUNT      = 24;
    localparam int ITER_W          = $clog2(ATAN_COUNT);

    localparam logic [31:0] ATAN_TAB [ATAN_COUNT] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef logic [21:0] frac45_t [45];

    function automatic frac45_t build_frac45();
        frac45_t t;
        for (int v = 0; v < 45; v++)
        begin
            t[v] = 22'(((64'(v) << 22) + 64'd22) / 64'd45);
        end
        return t;
    endfunction

    localparam frac45_t FRAC45 = build_frac45();

    typedef enum logic [2:0] {
        OP_FWD    = 3'd0,
        OP_BACK   = 3'd1,
        OP_LEFT   = 3'd2,
        OP_RIGHT  = 3'd3,
        OP_ROTATE = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROT,
        S_YSTART,
        S_YWAIT,
        S_PSTART,
        S_PWAIT,
        S_FRONT_MUL,
        S_FRONT_WR,
        S_SPEED,
        S_SPEED_WR,
        S_AXIS_MUL,
        S_AXIS_ADD,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_RECIP,
        CS_BAM,
        CS_ITER,
        CS_DONE
    } cstate_t;

    function automatic logic signed [15:0] q15_round(logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd16384) >>> 15;
        if (t > 34'sd32767)
            t = 34'sd32767;
        else if (t < -34'sd32767)
            t = -34'sd32767;
        return 16'(t);
    endfunction

endpackage

/* hdl/yaw_pitch_camera_update.sv */
// Top level of the yaw/pitch fly camera update block.
// Sine and cosine come from an iterative CORDIC; moves use one shared multiplier.
// Throughput: one command at a time; in_ready is high only when the sequencer is idle.
// Reset: position (0, 0, 2.0), yaw 270 degrees, pitch 0, front (0, 0, -1), speed 40.0.
module yaw_pitch_camera_update
    import ypcam_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         op,
    input  logic [15:0]        time_step,
    input  logic signed [15:0] yaw_step,
    input  logic signed [15:0] pitch_step,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [15:0] front_x,
    output logic signed [15:0] front_y,
    output logic signed [15:0] front_z,
    output logic [15:0]        yaw_now,
    output logic signed [14:0] pitch_now
);

    state_t                state_reg, state_next;
    logic [15:0]           move_speed_reg;
    logic signed [31:0]    pos_reg [3];
    logic signed [15:0]    front_reg [3];
    logic [15:0]           yaw_reg;
    logic signed [14:0]    pitch_reg;
    logic signed [15:0]    cy_reg, sy_reg, cp_reg, sp_reg;
    logic [31:0]           m_reg;
    logic signed [50:0]    prod_reg;
    logic [1:0]            axis_reg;
    op_t                   op_reg;
    logic [15:0]           dt_reg;
    logic signed [15:0]    ystep_reg, pstep_reg;
    logic                  out_valid_reg;

    logic                  cor_start, cor_done;
    logic signed [16:0]    cor_angle;
    logic signed [15:0]    cor_cos, cor_sin;

    logic                  strafe, sub, rotate;
    logic signed [15:0]    dir;
    logic [15:0]           dir_mag;
    logic                  move_neg;
    logic signed [33:0]    mul_a;
    logic signed [16:0]    mul_b;
    logic [47:0]           dmag;
    logic signed [35:0]    delta, psum_axis;
    logic signed [31:0]    pos_sat;
    logic signed [17:0]    ysum;
    logic signed [16:0]    psum;
    logic [15:0]           yaw_wrap;
    logic signed [14:0]    pitch_clamp;
    logic                  out_load;

    ypcam_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_q15 (cor_cos),
        .sin_q15 (cor_sin)
    );

    assign strafe = (op_reg == OP_LEFT) || (op_reg == OP_RIGHT);
    assign sub    = (op_reg == OP_BACK) || (op_reg == OP_LEFT);
    assign rotate = (op_reg == OP_ROTATE);

    always_comb
    begin
        unique case (axis_reg)
            2'd0:    dir = strafe ? -sy_reg : front_reg[0];
            2'd1:    dir = strafe ? 16'sd0 : front_reg[1];
            2'd2:    dir = strafe ? cy_reg : front_reg[2];
            default: dir = 16'sd0;
        endcase
        dir_mag  = 16'(dir[15] ? -dir : dir);
        move_neg = dir[15] ^ sub;
    end

    always_comb
    begin
        unique case (state_reg)
            S_SPEED:
            begin
                mul_a = $signed({18'b0, move_speed_reg});
                mul_b = $signed({1'b0, dt_reg});
            end
            S_AXIS_MUL:
            begin
                mul_a = $signed({2'b0, m_reg});
                mul_b = $signed({1'b0, dir_mag});
            end
            S_FRONT_MUL:
            begin
                mul_a = 34'((axis_reg == 2'd0) ? cy_reg : sy_reg);
                mul_b = 17'(cp_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        dmag      = (prod_reg[47:0] + (48'd1 << (MOVE_SHIFT - 1))) >> MOVE_SHIFT;
        delta     = move_neg ? -$signed(36'(dmag)) : $signed(36'(dmag));
        psum_axis = 36'(pos_reg[axis_reg]) + delta;
        if (psum_axis > 36'sh0_7FFF_FFFF)
            pos_sat = 32'sh7FFF_FFFF;
        else if (psum_axis < -36'sh0_8000_0000)
            pos_sat = 32'sh8000_0000;
        else
            pos_sat = 32'(psum_axis);
    end

    always_comb
    begin
        ysum = $signed({2'b0, yaw_reg}) + 18'(ystep_reg);
        if (ysum < 18'sd0)
            ysum = ysum + 18'(YAW_FULL);
        else if (ysum >= 18'(YAW_FULL))
            ysum = ysum - 18'(YAW_FULL);
        yaw_wrap = 16'(ysum);
        psum = 17'(pitch_reg) + 17'(pstep_reg);
        if (psum > 17'(PITCH_LIMIT))
            pitch_clamp = 15'(PITCH_LIMIT);
        else if (psum < -17'(PITCH_LIMIT))
            pitch_clamp = -15'(PITCH_LIMIT);
        else
            pitch_clamp = 15'(psum);
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    priority case (op)
                        OP_FWD, OP_BACK:    state_next = S_SPEED;
                        OP_LEFT, OP_RIGHT:  state_next = S_YSTART;
                        OP_ROTATE:          state_next = S_ROT;
                        default:            state_next = S_OUT;
                    endcase
                end
            end
            S_ROT:       state_next = S_YSTART;
            S_YSTART:    state_next = S_YWAIT;
            S_YWAIT:     if (cor_done) state_next = rotate ? S_PSTART : S_SPEED;
            S_PSTART:    state_next = S_PWAIT;
            S_PWAIT:     if (cor_done) state_next = S_FRONT_MUL;
            S_FRONT_MUL: state_next = S_FRONT_WR;
            S_FRONT_WR:  state_next = (axis_reg == 2'd0) ? S_FRONT_MUL : S_OUT;
            S_SPEED:     state_next = S_SPEED_WR;
            S_SPEED_WR:  state_next = S_AXIS_MUL;
            S_AXIS_MUL:  state_next = S_AXIS_ADD;
            S_AXIS_ADD:  state_next = (axis_reg == 2'd2) ? S_OUT : S_AXIS_MUL;
            S_OUT:       if (out_load) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        cor_start = (state_reg == S_YSTART) || (state_reg == S_PSTART);
        cor_angle = (state_reg == S_PSTART) ? 17'(pitch_reg) : $signed({1'b0, yaw_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            move_speed_reg <= 16'd10240;
            pos_reg[0]     <= 32'sd0;
            pos_reg[1]     <= 32'sd0;
            pos_reg[2]     <= 32'sd131072;
            front_reg[0]   <= 16'sd0;
            front_reg[1]   <= 16'sd0;
            front_reg[2]   <= -16'sd32767;
            yaw_reg        <= 16'd34560;
            pitch_reg      <= 15'sd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                move_speed_reg <= cfg_wr_data;
            if (state_reg == S_ROT)
            begin
                yaw_reg   <= yaw_wrap;
                pitch_reg <= pitch_clamp;
            end
            if (state_reg == S_AXIS_ADD)
                pos_reg[axis_reg] <= pos_sat;
            if (state_reg == S_FRONT_WR)
            begin
                if (axis_reg == 2'd0)
                    front_reg[0] <= q15_round(prod_reg[33:0]);
                else
                begin
                    front_reg[2] <= q15_round(prod_reg[33:0]);
                    front_reg[1] <= sp_reg;
                end
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 51'(mul_a) * 51'(mul_b);
        if (in_valid && in_ready)
        begin
            op_reg    <= op_t'(op);
            dt_reg    <= time_step;
            ystep_reg <= yaw_step;
            pstep_reg <= pitch_step;
        end
        unique case (state_reg)
            S_IDLE:      axis_reg <= 2'd0;
            S_YWAIT:
            begin
                if (cor_done)
                begin
                    cy_reg <= cor_cos;
                    sy_reg <= cor_sin;
                end
            end
            S_PWAIT:
            begin
                if (cor_done)
                begin
                    cp_reg <= cor_cos;
                    sp_reg <= cor_sin;
                end
            end
            S_FRONT_WR:  axis_reg <= axis_reg + 2'd1;
            S_SPEED_WR:  m_reg <= prod_reg[31:0];
            S_AXIS_ADD:  axis_reg <= axis_reg + 2'd1;
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            pos_x     <= pos_reg[0];
            pos_y     <= pos_reg[1];
            pos_z     <= pos_reg[2];
            front_x   <= front_reg[0];
            front_y   <= front_reg[1];
            front_z   <= front_reg[2];
            yaw_now   <= yaw_reg;
            pitch_now <= pitch_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hdl/ypcam_cordic.sv */
// Iterative rotation-mode CORDIC: angle in 1/128 degree to cos and sin in Q1.15.
module ypcam_cordic
    import ypcam_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [16:0]  angle,
    output logic                done,
    output logic signed [15:0]  cos_q15,
    output logic signed [15:0]  sin_q15
);

    cstate_t                state_reg, state_next;
    logic                   neg_reg;
    logic [15:0]            mag_reg;
    logic [10:0]            u_reg;
    logic signed [33:0]     x_reg, y_reg, z_reg;
    logic                   flip_reg;
    logic [ITER_W-1:0]      iter_reg;

    logic [31:0]            recip_prod;
    logic [5:0]             v_rem;
    logic signed [33:0]     z_abs, z_sgn, z_fold;
    logic                   fold;
    logic signed [33:0]     dx, dy, atan_e;
    logic                   last_iter;

    assign recip_prod = 32'(mag_reg) * 32'(RECIP45);
    assign v_rem      = 6'(mag_reg - 16'(u_reg) * 16'd45);
    assign z_abs      = {1'b0, u_reg, 22'b0} + 34'(FRAC45[v_rem]);
    assign dx         = y_reg >>> iter_reg;
    assign dy         = x_reg >>> iter_reg;
    assign atan_e     = $signed({2'b0, ATAN_TAB[iter_reg]});
    assign last_iter  = (iter_reg == ITER_W'(TRIG_ITERATIONS - 1));

    always_comb
    begin
        z_sgn = neg_reg ? -z_abs : z_abs;
        if (z_sgn >= 34'sh0_8000_0000)
            z_sgn = z_sgn - 34'sh1_0000_0000;
        fold   = 1'b0;
        z_fold = z_sgn;
        if (z_sgn > 34'sh0_4000_0000)
        begin
            z_fold = z_sgn - 34'sh0_8000_0000;
            fold   = 1'b1;
        end
        else if (z_sgn < -34'sh0_4000_0000)
        begin
            z_fold = z_sgn + 34'sh0_8000_0000;
            fold   = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:  if (start) state_next = CS_RECIP;
            CS_RECIP: state_next = CS_BAM;
            CS_BAM:   state_next = CS_ITER;
            CS_ITER:  if (last_iter) state_next = CS_DONE;
            CS_DONE:  state_next = CS_IDLE;
            default:  state_next = CS_IDLE;
        endcase
    end

    always_comb
    begin
        done    = (state_reg == CS_DONE);
        cos_q15 = q15_round(flip_reg ? -x_reg : x_reg);
        sin_q15 = q15_round(flip_reg ? -y_reg : y_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            CS_IDLE:
            begin
                neg_reg <= angle[16];
                mag_reg <= 16'(angle[16] ? -angle : angle);
            end
            CS_RECIP:
            begin
                u_reg <= recip_prod[31:21];
            end
            CS_BAM:
            begin
                z_reg    <= z_fold;
                flip_reg <= fold;
                x_reg    <= 34'(CORDIC_GAIN);
                y_reg    <= '0;
                iter_reg <= '0;
            end
            CS_ITER:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_e;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_e;
                end
                iter_reg <= iter_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* hdl/ypcam_checker.sv */
// Port-level checks for the yaw/pitch camera update block, bound to the top level.
module ypcam_checker
    import ypcam_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] pos_x,
    input logic signed [15:0] front_x,
    input logic signed [15:0] front_y,
    input logic signed [15:0] front_z,
    input logic [15:0]        yaw_now,
    input logic signed [14:0] pitch_now
);

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block took a second beat while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(yaw_now))
        else $error("stalled result changed");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> yaw_now < 16'(YAW_FULL)
            && pitch_now <= 15'sd11392 && pitch_now >= -15'sd11392)
        else $error("angle out of range");

    a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> front_x != -16'sd32768 && front_y != -16'sd32768
            && front_z != -16'sd32768)
        else $error("front component out of range");

endmodule

bind yaw_pitch_camera_update ypcam_checker u_ypcam_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pos_x     (pos_x),
    .front_x   (front_x),
    .front_y   (front_y),
    .front_z   (front_z),
    .yaw_now   (yaw_now),
    .pitch_now (pitch_now)
);
